// ----- rtl/core/sbfd_pkg.sv -----
// Shared types, codes and constants for the binary block deframer.
package sbfd_pkg;

	localparam int unsigned MaxBlockBytes = 4096;

	localparam logic [7:0]  SyncFirst  = 8'h24;
	localparam logic [7:0]  SyncSecond = 8'h40;
	localparam logic [15:0] CrcPoly    = 16'h1021;

	localparam logic [12:0] PvtIdReset  = 13'd4007;
	localparam logic [12:0] MeasIdReset = 13'd4027;
	localparam logic [12:0] TimeIdReset = 13'd5914;

	localparam int unsigned NumSlots = 6;

	typedef enum logic [1:0] {
		CfgPvtId  = 2'd0,
		CfgMeasId = 2'd1,
		CfgTimeId = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		StatusOk  = 2'd0,
		StatusCrc = 2'd1,
		StatusLen = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KindPvt     = 2'd0,
		KindMeas    = 2'd1,
		KindTime    = 2'd2,
		KindUnknown = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		SlotPvt     = 3'd0,
		SlotMeas    = 3'd1,
		SlotTime    = 3'd2,
		SlotUnknown = 3'd3,
		SlotCrc     = 3'd4,
		SlotLen     = 3'd5
	} slot_t;

	typedef struct packed {
		status_t     status;
		kind_t       kind;
		logic [12:0] number;
		logic [15:0] length;
		slot_t       slot;
	} frame_res_t;

endpackage

// ----- rtl/core/sbf_block_deframer_crc_unit.sv -----
// Top level of the binary block deframer with CRC-16 check and event counters.
// A completing byte is registered at the input, then its frame result at the output.
// Throughput: one byte per cycle; a result held on the output stalls the input side.
// Per-byte work (CRC update, header capture, classify) sits between those two registers.
// Reset: asynchronous, active low; hunts for sync, counters zero, IDs at defaults.
module sbf_block_deframer_crc_unit #(
	parameter int unsigned MAX_BLOCK_BYTES = sbfd_pkg::MaxBlockBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [12:0] block_number, [28:13] block_length,
	                                    // [60:29] event_count, [63:61] zero
	output logic [3:0]  m_axis_tuser,   // [1:0] frame_status, [3:2] block_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 step;
	logic                 res_valid;
	sbfd_pkg::frame_res_t res;
	logic [31:0]          count_next;
	logic                 out_valid_q;
	logic [63:0]          out_data_q;
	logic [3:0]           out_user_q;

	assign cfg_ready     = 1'b1;
	assign step          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	sbfd_deframer #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sbfd_counters u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.bump       (res_valid),
		.slot       (res.slot),
		.count_next (count_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= {3'b000, count_next, res.length, res.number};
			out_user_q <= {res.kind, res.status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/core/sbfd_counters.sv -----
// Six wrapping frame event counters; returns the bumped value.
module sbfd_counters (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bump,
	input  sbfd_pkg::slot_t    slot,
	output logic [31:0]        count_next
);

	logic [31:0] cnt_q [sbfd_pkg::NumSlots];

	assign count_next = cnt_q[slot] + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbfd_pkg::NumSlots; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (bump) begin
			cnt_q[slot] <= count_next;
		end
	end

endmodule

// ----- rtl/core/sbfd_deframer.sv -----
// Sync hunt, header capture, CRC-16 check and block classification.
module sbfd_deframer #(
	parameter int unsigned MAX_BLOCK_BYTES = sbfd_pkg::MaxBlockBytes
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [12:0]          cfg_data,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	output sbfd_pkg::frame_res_t res
);

	localparam logic [12:0] MaxCount  = 13'(MAX_BLOCK_BYTES);
	localparam logic [15:0] MaxLength = 16'(MAX_BLOCK_BYTES);

	logic [12:0] pvt_id_q, meas_id_q, time_id_q;
	logic [12:0] cnt_q, cnt_d, cnt_inc;
	logic [15:0] len_q, len_d;
	logic [15:0] rx_crc_q, rx_crc_d;
	logic [15:0] crc_q, crc_d, crc_new;
	logic [15:0] id_q, id_d;
	logic        emit;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ sbfd_pkg::CrcPoly) : (c << 1);
		end
		return c;
	endfunction

	assign cnt_inc = cnt_q + 13'd1;
	assign crc_new = crc_byte(crc_q, rx_byte);

	always_comb begin
		cnt_d      = cnt_q;
		len_d      = len_q;
		rx_crc_d   = rx_crc_q;
		crc_d      = crc_q;
		id_d       = id_q;
		emit       = 1'b0;
		res.status = sbfd_pkg::StatusOk;
		res.kind   = sbfd_pkg::KindUnknown;
		res.slot   = sbfd_pkg::SlotUnknown;
		if (cnt_q == 13'd0) begin
			if (rx_byte == sbfd_pkg::SyncFirst) begin
				cnt_d = 13'd1;
			end
		end else if (cnt_q == 13'd1) begin
			if (rx_byte == sbfd_pkg::SyncSecond) begin
				cnt_d = 13'd2;
				crc_d = '0;
			end else if (rx_byte != sbfd_pkg::SyncFirst) begin
				cnt_d = '0;
				len_d = '0;
				crc_d = '0;
			end
		end else if (cnt_q >= MaxCount) begin
			cnt_d = '0;
			len_d = '0;
			crc_d = '0;
		end else begin
			cnt_d = cnt_inc;
			if (cnt_q >= 13'd4) begin
				crc_d = crc_new;
			end
			case (cnt_q)
				13'd2: rx_crc_d[7:0]  = rx_byte;
				13'd3: rx_crc_d[15:8] = rx_byte;
				13'd4: id_d[7:0]      = rx_byte;
				13'd5: id_d[15:8]     = rx_byte;
				13'd6: len_d[7:0]     = rx_byte;
				13'd7: len_d[15:8]    = rx_byte;
				default: ;
			endcase
			if (cnt_q == 13'd7 &&
			    (len_d < 16'd8 || len_d[1:0] != 2'b00 || len_d > MaxLength)) begin
				emit       = 1'b1;
				res.status = sbfd_pkg::StatusLen;
				res.slot   = sbfd_pkg::SlotLen;
			end else if (cnt_inc >= 13'd8 && {3'b000, cnt_inc} == len_d) begin
				emit = 1'b1;
				if (crc_d != rx_crc_d) begin
					res.status = sbfd_pkg::StatusCrc;
					res.slot   = sbfd_pkg::SlotCrc;
				end else if (id_d[12:0] == pvt_id_q) begin
					res.kind = sbfd_pkg::KindPvt;
					res.slot = sbfd_pkg::SlotPvt;
				end else if (id_d[12:0] == meas_id_q) begin
					res.kind = sbfd_pkg::KindMeas;
					res.slot = sbfd_pkg::SlotMeas;
				end else if (id_d[12:0] == time_id_q) begin
					res.kind = sbfd_pkg::KindTime;
					res.slot = sbfd_pkg::SlotTime;
				end
			end
		end
		res.number = id_d[12:0];
		res.length = len_d;
		if (emit) begin
			cnt_d = '0;
			len_d = '0;
			crc_d = '0;
		end
	end

	assign res_valid = step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			len_q    <= '0;
			rx_crc_q <= '0;
			crc_q    <= '0;
			id_q     <= '0;
		end else if (step) begin
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			rx_crc_q <= rx_crc_d;
			crc_q    <= crc_d;
			id_q     <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvt_id_q  <= sbfd_pkg::PvtIdReset;
			meas_id_q <= sbfd_pkg::MeasIdReset;
			time_id_q <= sbfd_pkg::TimeIdReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbfd_pkg::CfgPvtId:  pvt_id_q  <= cfg_data;
				sbfd_pkg::CfgMeasId: meas_id_q <= cfg_data;
				sbfd_pkg::CfgTimeId: time_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the binary block deframer with CRC-16 check and event counters.
module testbench;
	import sbfd_pkg::*;

	typedef struct {
		status_t     status;
		kind_t       kind;
		logic [12:0] number;
		logic [15:0] length;
		logic [31:0] count;
	} frame_result_t;

	localparam logic [1:0] CfgBadIndex   = 2'd3;
	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned TailCycles    = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [12:0] cfg_data = 13'd0;

	logic [7:0]    rx_bytes_q[$];
	frame_result_t pending_frames[$];
	int            mismatches = 0;
	int            frame_bytes = 0;
	int            send_gap = 0;
	int            stall_left = 0;
	int            idle_cycles = 0;
	bit            s_idle_on = 1'b0;
	bit            m_idle_on = 1'b0;

	logic [12:0] pvt_id = PvtIdReset;
	logic [12:0] meas_id = MeasIdReset;
	logic [12:0] time_id = TimeIdReset;
	logic [12:0] frame_pos = 13'd0;
	logic [15:0] len_field = 16'd0;
	logic [15:0] crc_field = 16'd0;
	logic [15:0] crc_acc = 16'd0;
	logic [15:0] id_word = 16'd0;
	logic [31:0] tally[NumSlots] = '{default: 32'd0};

	sbf_block_deframer_crc_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
		end
		return crc;
	endfunction

	function automatic int draw_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void restart_hunt();
		frame_pos = 13'd0;
		len_field = 16'd0;
		crc_acc = 16'd0;
	endfunction

	function automatic void close_frame(status_t st, kind_t k, slot_t slot);
		frame_result_t r;
		tally[slot] = tally[slot] + 32'd1;
		r.status = st;
		r.kind = k;
		r.number = id_word[12:0];
		r.length = len_field;
		r.count = tally[slot];
		pending_frames.push_back(r);
		restart_hunt();
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		logic [12:0] pos;
		logic [12:0] num;
		if (frame_pos == 13'd0) begin
			if (b == SyncFirst)
				frame_pos = 13'd1;
			return;
		end
		if (frame_pos == 13'd1) begin
			if (b == SyncSecond) begin
				frame_pos = 13'd2;
				crc_acc = 16'd0;
			end else if (b != SyncFirst) begin
				restart_hunt();
			end
			return;
		end
		if (frame_pos >= MaxBlockBytes) begin
			restart_hunt();
			return;
		end
		pos = frame_pos;
		frame_pos = frame_pos + 13'd1;
		if (pos >= 13'd4)
			crc_acc = crc16_step(crc_acc, b);
		case (pos)
			13'd2: crc_field[7:0] = b;
			13'd3: crc_field[15:8] = b;
			13'd4: id_word[7:0] = b;
			13'd5: id_word[15:8] = b;
			13'd6: len_field[7:0] = b;
			13'd7: begin
				len_field[15:8] = b;
				if (len_field < 16'd8 || len_field[1:0] != 2'd0 || len_field > MaxBlockBytes) begin
					close_frame(StatusLen, KindUnknown, SlotLen);
					return;
				end
			end
			default: ;
		endcase
		if (frame_pos >= 13'd8 && {3'd0, frame_pos} == len_field) begin
			num = id_word[12:0];
			if (crc_acc != crc_field)
				close_frame(StatusCrc, KindUnknown, SlotCrc);
			else if (num == pvt_id)
				close_frame(StatusOk, KindPvt, SlotPvt);
			else if (num == meas_id)
				close_frame(StatusOk, KindMeas, SlotMeas);
			else if (num == time_id)
				close_frame(StatusOk, KindTime, SlotTime);
			else
				close_frame(StatusOk, KindUnknown, SlotUnknown);
		end
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	task automatic add_frame(logic [15:0] len, logic [15:0] id, bit bad_crc, int body);
		logic [7:0]  payload[$];
		logic [7:0]  b;
		logic [15:0] crc;
		crc = 16'd0;
		crc = crc16_step(crc, id[7:0]);
		crc = crc16_step(crc, id[15:8]);
		crc = crc16_step(crc, len[7:0]);
		crc = crc16_step(crc, len[15:8]);
		repeat (body) begin
			b = ($urandom_range(0, 15) == 0) ? SyncFirst : 8'($urandom);
			payload.push_back(b);
			crc = crc16_step(crc, b);
		end
		if (bad_crc)
			crc = crc ^ (16'd1 << $urandom_range(0, 15));
		rx_bytes_q.push_back(SyncFirst);
		rx_bytes_q.push_back(SyncSecond);
		rx_bytes_q.push_back(crc[7:0]);
		rx_bytes_q.push_back(crc[15:8]);
		rx_bytes_q.push_back(id[7:0]);
		rx_bytes_q.push_back(id[15:8]);
		rx_bytes_q.push_back(len[7:0]);
		rx_bytes_q.push_back(len[15:8]);
		foreach (payload[i])
			rx_bytes_q.push_back(payload[i]);
		frame_bytes += 8 + body;
	endtask

	function automatic logic [15:0] pick_id();
		logic [12:0] num;
		case ($urandom_range(0, 4))
			0: num = pvt_id;
			1: num = meas_id;
			2: num = time_id;
			default: num = 13'($urandom);
		endcase
		return {3'($urandom), num};
	endfunction

	task automatic random_traffic(int n);
		int          r;
		logic [15:0] len;
		frame_bytes = 0;
		while (frame_bytes < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = 16'(4 * $urandom_range(2, 16));
				add_frame(len, pick_id(), $urandom_range(0, 7) == 0, len - 8);
			end else if (r < 80) begin
				case ($urandom_range(0, 3))
					0: len = 16'($urandom_range(0, 7));
					1: len = 16'(4 * $urandom_range(2, 1024) + $urandom_range(1, 3));
					2: len = 16'($urandom_range(MaxBlockBytes + 1, 65535));
					default: len = 16'(MaxBlockBytes + 4);
				endcase
				add_frame(len, pick_id(), $urandom_range(0, 1), 0);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6))
					rx_bytes_q.push_back(($urandom_range(0, 2) == 0) ? SyncFirst : 8'($urandom));
			end else begin
				rx_bytes_q.push_back(SyncFirst);
				rx_bytes_q.push_back(SyncSecond);
				repeat ($urandom_range(0, 6))
					rx_bytes_q.push_back(8'($urandom));
				frame_bytes += 2;
			end
		end
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [12:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CfgPvtId: pvt_id = value;
			CfgMeasId: meas_id = value;
			CfgTimeId: time_id = value;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (rx_bytes_q.size() != 0 || s_axis_tvalid || pending_frames.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the pending transfer
			end else if (send_gap != 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (rx_bytes_q.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_bytes_q.pop_front();
				send_gap = draw_gap(s_idle_on);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		frame_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_frames.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = pending_frames.pop_front();
					if (m_axis_tuser[1:0] != want.status)
						report_mismatch("frame_status", m_axis_tuser[1:0], want.status);
					if (m_axis_tuser[3:2] != want.kind)
						report_mismatch("block_kind", m_axis_tuser[3:2], want.kind);
					if (m_axis_tdata[12:0] != want.number)
						report_mismatch("block_number", m_axis_tdata[12:0], want.number);
					if (m_axis_tdata[28:13] != want.length)
						report_mismatch("block_length", m_axis_tdata[28:13], want.length);
					if (m_axis_tdata[60:29] != want.count)
						report_mismatch("event_count", m_axis_tdata[60:29], want.count);
				end
				stall_left = draw_gap(m_idle_on);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WatchdogLimit) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults, no idling: repeated sync, aborted sync, bad length, crc reject
		rx_bytes_q.push_back(SyncFirst);
		add_frame(16'd8, {3'd0, PvtIdReset}, 1'b0, 0);
		rx_bytes_q.push_back(SyncFirst);
		rx_bytes_q.push_back(8'h11);
		add_frame(16'd6, 16'hFF00, 1'b0, 0);
		add_frame(16'd8, {3'd7, MeasIdReset}, 1'b1, 0);
		drain();

		// equal IDs at the low extreme
		s_idle_on = 1'b1;
		m_idle_on = 1'b1;
		cfg_write(CfgPvtId, 13'd0);
		cfg_write(CfgMeasId, 13'd0);
		cfg_write(CfgTimeId, 13'h1FFF);
		random_traffic(300);
		drain();

		// stray index, then all IDs at the high extreme
		m_idle_on = 1'b0;
		cfg_write(CfgBadIndex, 13'd5);
		cfg_write(CfgPvtId, 13'h1FFF);
		cfg_write(CfgMeasId, 13'h1FFF);
		cfg_write(CfgTimeId, 13'h1FFF);
		random_traffic(250);
		drain();

		m_idle_on = 1'b1;
		cfg_write(CfgPvtId, 13'($urandom));
		cfg_write(CfgMeasId, 13'($urandom));
		cfg_write(CfgTimeId, 13'($urandom));
		random_traffic(250);
		drain();

		if (pending_frames.size() != 0)
			report_mismatch("frames never delivered", pending_frames.size(), 0);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
